// ===== rtl/glcd_pkg.sv =====
// Shared types and constants for the glyph to LCD SPI byte stream block.
package glcd_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgColOffset = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRowOffset = 2'd1;

  // Glyph geometry
  localparam int unsigned GlyphBytes = 32;
  localparam int unsigned IdxW       = 5;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(GlyphBytes - 1);
  localparam logic [7:0] WinSpan = 8'd15;

  // Panel commands
  localparam logic [7:0] CmdColSet = 8'h2A;
  localparam logic [7:0] CmdRowSet = 8'h2B;
  localparam logic [7:0] CmdMemWr  = 8'h2C;

  // Output sequence positions: window bytes first, then 16 pixel bytes
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] StepColCmd = 5'd0;
  localparam logic [StepW-1:0] StepCsHi   = 5'd1;
  localparam logic [StepW-1:0] StepCsLo   = 5'd2;
  localparam logic [StepW-1:0] StepCeHi   = 5'd3;
  localparam logic [StepW-1:0] StepCeLo   = 5'd4;
  localparam logic [StepW-1:0] StepRowCmd = 5'd5;
  localparam logic [StepW-1:0] StepRsHi   = 5'd6;
  localparam logic [StepW-1:0] StepRsLo   = 5'd7;
  localparam logic [StepW-1:0] StepReHi   = 5'd8;
  localparam logic [StepW-1:0] StepReLo   = 5'd9;
  localparam logic [StepW-1:0] StepMemCmd = 5'd10;
  localparam logic [StepW-1:0] StepPixel0 = 5'd11;
  localparam logic [StepW-1:0] StepFinal  = 5'd26;

  // One classified item, as queued between front and back
  typedef struct packed {
    logic        first;
    logic        glyph_last;
    logic [7:0]  bits;
    logic [15:0] color;
    logic [9:0]  col_start;
    logic [9:0]  col_end;
    logic [7:0]  row_start;
    logic [7:0]  row_end;
  } glcd_entry_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } glcd_qstat_t;

endpackage

// ===== rtl/glcd_if.sv =====
// Valid/ready channel interfaces for glyph input and SPI byte output.
interface glcd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  glyph_byte;
  logic [8:0]  pos_x;
  logic [7:0]  pos_y;
  logic [15:0] fg_color;

  modport source (output valid, glyph_byte, pos_x, pos_y, fg_color, input ready);
  modport sink   (input valid, glyph_byte, pos_x, pos_y, fg_color, output ready);
endinterface

interface glcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       is_data;
  logic       run_last;
  logic       glyph_done;

  modport source (output valid, spi_byte, is_data, run_last, glyph_done, input ready);
  modport sink   (input valid, spi_byte, is_data, run_last, glyph_done, output ready);
endinterface

// ===== rtl/glcd_front.sv =====
// Front end: accepts glyph bytes, tracks position, computes the window.
module glcd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [glcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [glcd_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    glyph_byte_i,
  input  logic [8:0]                    pos_x_i,
  input  logic [7:0]                    pos_y_i,
  input  logic [15:0]                   fg_color_i,
  input  glcd_pkg::glcd_qstat_t         qstat_i,
  output logic                          push_o,
  output glcd_pkg::glcd_entry_t         entry_o
);
  import glcd_pkg::*;

  logic [7:0]      col_off_q, row_off_q;
  logic [IdxW-1:0] byte_idx_q, byte_idx_d;
  logic [15:0]     held_color_q, held_color_d;
  logic            first;
  logic [9:0]      col_start;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_off_q <= '0;
      row_off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgColOffset: col_off_q <= cfg_wdata_i;
        CfgRowOffset: row_off_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && in_ready_o;
  assign first      = (byte_idx_q == '0);

  // Classify the item and work out the window coordinates
  assign col_start = {1'b0, pos_x_i} + {2'b00, col_off_q};
  always_comb begin
    entry_o.first      = first;
    entry_o.glyph_last = (byte_idx_q == IdxLast);
    entry_o.bits       = glyph_byte_i;
    entry_o.color      = first ? fg_color_i : held_color_q;
    entry_o.col_start  = col_start;
    entry_o.col_end    = col_start + {2'b00, WinSpan};
    entry_o.row_start  = pos_y_i + row_off_q;
    entry_o.row_end    = pos_y_i + row_off_q + WinSpan;
  end

  // Position within glyph and latched colour
  always_comb begin
    byte_idx_d   = byte_idx_q;
    held_color_d = held_color_q;
    if (push_o) begin
      byte_idx_d   = byte_idx_q + 1'b1;
      held_color_d = entry_o.color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_idx_q   <= '0;
      held_color_q <= '0;
    end else begin
      byte_idx_q   <= byte_idx_d;
      held_color_q <= held_color_d;
    end
  end

endmodule

// ===== rtl/glcd_queue.sv =====
// Short register queue between front and back ends.
module glcd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  glcd_pkg::glcd_entry_t entry_i,
  input  logic                  pop_i,
  output glcd_pkg::glcd_entry_t entry_o,
  output glcd_pkg::glcd_qstat_t qstat_o
);
  import glcd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  glcd_entry_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign qstat_o.full  = (count_q == CntFull);
  assign qstat_o.empty = (count_q == '0);
  assign entry_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/glcd_back.sv =====
// Back end: sequences window and pixel bytes into a registered output.
module glcd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  glcd_pkg::glcd_entry_t entry_i,
  input  glcd_pkg::glcd_qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            spi_byte_o,
  output logic                  is_data_o,
  output logic                  run_last_o,
  output logic                  glyph_done_o
);
  import glcd_pkg::*;

  glcd_entry_t      cur_q, cur_d;
  logic             busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       spi_byte_q, spi_byte_d;
  logic             is_data_q, is_data_d;
  logic             run_last_q, run_last_d;
  logic             glyph_done_q, glyph_done_d;
  logic             adv, last_step;
  logic [StepW-1:0] pix_idx;
  logic [7:0]       byte_val;
  logic             byte_data;

  assign adv       = busy_q && (!out_valid_q || out_ready_i);
  assign last_step = (step_q == StepFinal);
  assign pop_o     = !qstat_i.empty && (!busy_q || (adv && last_step));
  assign pix_idx   = step_q - StepPixel0;

  // Byte for the current step
  always_comb begin
    byte_val  = '0;
    byte_data = 1'b1;
    case (step_q)
      StepColCmd: begin
        byte_val  = CmdColSet;
        byte_data = 1'b0;
      end
      StepCsHi:   byte_val = {6'd0, cur_q.col_start[9:8]};
      StepCsLo:   byte_val = cur_q.col_start[7:0];
      StepCeHi:   byte_val = {6'd0, cur_q.col_end[9:8]};
      StepCeLo:   byte_val = cur_q.col_end[7:0];
      StepRowCmd: begin
        byte_val  = CmdRowSet;
        byte_data = 1'b0;
      end
      StepRsHi:   byte_val = '0;
      StepRsLo:   byte_val = cur_q.row_start;
      StepReHi:   byte_val = '0;
      StepReLo:   byte_val = cur_q.row_end;
      StepMemCmd: begin
        byte_val  = CmdMemWr;
        byte_data = 1'b0;
      end
      default: begin
        // Pixel bytes: two per bitmap bit, LSB first, colour high then low
        if (cur_q.bits[pix_idx[3:1]]) begin
          byte_val = pix_idx[0] ? cur_q.color[7:0] : cur_q.color[15:8];
        end
      end
    endcase
  end

  // Sequencer and output register
  always_comb begin
    cur_d        = cur_q;
    busy_d       = busy_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    spi_byte_d   = spi_byte_q;
    is_data_d    = is_data_q;
    run_last_d   = run_last_q;
    glyph_done_d = glyph_done_q;
    if (adv) begin
      out_valid_d  = 1'b1;
      spi_byte_d   = byte_val;
      is_data_d    = byte_data;
      run_last_d   = last_step;
      glyph_done_d = last_step && cur_q.glyph_last;
      step_d       = step_q + 1'b1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      cur_d  = entry_i;
      busy_d = 1'b1;
      step_d = entry_i.first ? StepColCmd : StepPixel0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    spi_byte_q   <= spi_byte_d;
    is_data_q    <= is_data_d;
    run_last_q   <= run_last_d;
    glyph_done_q <= glyph_done_d;
  end

  assign out_valid_o  = out_valid_q;
  assign spi_byte_o   = spi_byte_q;
  assign is_data_o    = is_data_q;
  assign run_last_o   = run_last_q;
  assign glyph_done_o = glyph_done_q;

endmodule

// ===== rtl/glyph_to_lcd_spi_stream.sv =====
// The first byte of an item passes the queue entry, the back-end item register
// and the output register. The back-end sequencer gives one output byte per
// cycle while the receiver is ready; an item is 16 bytes, or 27 for the first
// byte of a glyph (window command added). The input side keeps taking items
// while the queue has room. Reset: asynchronous, active low; clears offsets,
// glyph position, colour, queue and output valid.
module glyph_to_lcd_spi_stream #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [glcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [glcd_pkg::CfgDataW-1:0] cfg_wdata_i,
  glcd_in_if.sink                       in_if,
  glcd_out_if.source                    out_if
);
  import glcd_pkg::*;

  glcd_entry_t push_entry, pop_entry;
  glcd_qstat_t qstat;
  logic        push, pop;

  // Front end
  glcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .glyph_byte_i (in_if.glyph_byte),
    .pos_x_i      (in_if.pos_x),
    .pos_y_i      (in_if.pos_y),
    .fg_color_i   (in_if.fg_color),
    .qstat_i      (qstat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Queue between the two halves
  glcd_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .qstat_o (qstat)
  );

  // Back end
  glcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_i      (pop_entry),
    .qstat_i      (qstat),
    .pop_o        (pop),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .spi_byte_o   (out_if.spi_byte),
    .is_data_o    (out_if.is_data),
    .run_last_o   (out_if.run_last),
    .glyph_done_o (out_if.glyph_done)
  );

`ifndef NO_ASSERTIONS
  // No transaction is taken into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) qstat.full |-> !in_if.ready)
    else $error("input ready while queue full");

  // Nothing is popped from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) qstat.empty |-> !pop)
    else $error("pop from empty queue");

  // End of glyph coincides with end of item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_if.valid && out_if.glyph_done |-> out_if.run_last)
    else $error("glyph_done without run_last");

  // Command bytes are only the three panel commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_if.valid && !out_if.is_data |->
                   (out_if.spi_byte == CmdColSet) || (out_if.spi_byte == CmdRowSet) ||
                   (out_if.spi_byte == CmdMemWr))
    else $error("unexpected command byte");
`endif

endmodule

// ===== verif/glcd_spi_scoreboard.sv =====
// Scoreboard for the glyph to LCD SPI stream: predicts every SPI byte and checks the output.
module glcd_spi_scoreboard (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [glcd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [glcd_pkg::CfgDataW-1:0] cfg_wdata_i,
  glcd_in_if                            in_if,
  glcd_out_if                           out_if,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   glyph_bytes_o,
  output int unsigned                   spi_bytes_o,
  output int unsigned                   glyphs_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import glcd_pkg::*;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       is_data;
    logic       run_last;
    logic       glyph_done;
  } spi_word_t;

  spi_word_t       spi_expected_q[$];
  logic [7:0]      col_offset;
  logic [7:0]      row_offset;
  logic [IdxW-1:0] glyph_pos;
  logic [15:0]     glyph_colour;
  int unsigned     fail_count;
  int unsigned     glyph_bytes;
  int unsigned     spi_bytes;
  int unsigned     glyphs;

  assign fail_count_o  = fail_count;
  assign glyph_bytes_o = glyph_bytes;
  assign spi_bytes_o   = spi_bytes;
  assign glyphs_o      = glyphs;

  function automatic void queue_spi_byte(input logic [7:0] value, input logic data);
    spi_word_t w;
    w.spi_byte   = value;
    w.is_data    = data;
    w.run_last   = 1'b0;
    w.glyph_done = 1'b0;
    spi_expected_q.push_back(w);
  endfunction

  // Expected SPI bytes for one glyph byte: window command on a new glyph, then 8 pixels
  function automatic void predict_spi_bytes(input logic [7:0] bits, input logic [8:0] x,
                                            input logic [7:0] y, input logic [15:0] colour);
    logic [9:0] col_start;
    logic [9:0] col_end;
    logic [7:0] row_start;
    logic [7:0] row_end;
    spi_word_t  tail;
    if (glyph_pos == '0) begin
      col_start    = 10'(x) + 10'(col_offset);
      col_end      = col_start + 10'(WinSpan);
      row_start    = y + row_offset;
      row_end      = row_start + WinSpan;
      glyph_colour = colour;
      queue_spi_byte(CmdColSet, 1'b0);
      queue_spi_byte(8'(col_start >> 8), 1'b1);
      queue_spi_byte(col_start[7:0], 1'b1);
      queue_spi_byte(8'(col_end >> 8), 1'b1);
      queue_spi_byte(col_end[7:0], 1'b1);
      queue_spi_byte(CmdRowSet, 1'b0);
      queue_spi_byte(8'h00, 1'b1);
      queue_spi_byte(row_start, 1'b1);
      queue_spi_byte(8'h00, 1'b1);
      queue_spi_byte(row_end, 1'b1);
      queue_spi_byte(CmdMemWr, 1'b0);
    end
    // LSB is the leftmost pixel; a clear bit draws black
    for (int i = 0; i < 8; i++) begin
      if (bits[i]) begin
        queue_spi_byte(glyph_colour[15:8], 1'b1);
        queue_spi_byte(glyph_colour[7:0], 1'b1);
      end else begin
        queue_spi_byte(8'h00, 1'b1);
        queue_spi_byte(8'h00, 1'b1);
      end
    end
    tail            = spi_expected_q.pop_back();
    tail.run_last   = 1'b1;
    tail.glyph_done = (glyph_pos == IdxLast);
    spi_expected_q.push_back(tail);
    if (glyph_pos == IdxLast) begin
      glyphs++;
    end
    glyph_pos = glyph_pos + 1'b1;
  endfunction

  // Compare one output transaction with the oldest expectation
  function automatic void check_spi_byte();
    spi_word_t want;
    spi_bytes++;
    if (spi_expected_q.size() == 0) begin
      $error("unexpected SPI byte %02h with nothing pending", out_if.spi_byte);
      fail_count++;
    end else begin
      want = spi_expected_q.pop_front();
      if (out_if.spi_byte !== want.spi_byte) begin
        $error("spi_byte: expected %02h, got %02h", want.spi_byte, out_if.spi_byte);
        fail_count++;
      end
      if (out_if.is_data !== want.is_data) begin
        $error("is_data: expected %0b, got %0b", want.is_data, out_if.is_data);
        fail_count++;
      end
      if (out_if.run_last !== want.run_last) begin
        $error("run_last: expected %0b, got %0b", want.run_last, out_if.run_last);
        fail_count++;
      end
      if (out_if.glyph_done !== want.glyph_done) begin
        $error("glyph_done: expected %0b, got %0b", want.glyph_done, out_if.glyph_done);
        fail_count++;
      end
    end
  endfunction

  initial begin
    fail_count  = 0;
    glyph_bytes = 0;
    spi_bytes   = 0;
    glyphs      = 0;
  end

  // Register writes, input transactions, then output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spi_expected_q.delete();
      col_offset   = '0;
      row_offset   = '0;
      glyph_pos    = '0;
      glyph_colour = '0;
      pending_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgColOffset: col_offset = cfg_wdata_i;
          CfgRowOffset: row_offset = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        glyph_bytes++;
        predict_spi_bytes(in_if.glyph_byte, in_if.pos_x, in_if.pos_y, in_if.fg_color);
      end
      if (out_if.valid && out_if.ready) begin
        check_spi_byte();
      end
      pending_o <= spi_expected_q.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the glyph to LCD SPI stream testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import glcd_pkg::*;

  localparam int unsigned CycleLimit     = 500000;
  localparam int unsigned SinkHoldCycles = 400;
  localparam int unsigned PhaseItems     = 69;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  glcd_in_if  in_if ();
  glcd_out_if out_if ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned glyph_bytes;
  int unsigned spi_bytes;
  int unsigned glyphs;
  int unsigned cycle_count = 0;
  int unsigned sink_hold_left = 0;
  int unsigned offset_settings = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;

  glyph_to_lcd_spi_stream DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  glcd_spi_scoreboard u_scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_if         (in_if),
    .out_if        (out_if),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .glyph_bytes_o (glyph_bytes),
    .spi_bytes_o   (spi_bytes),
    .glyphs_o      (glyphs)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off when requested
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_left != 0) begin
        out_if.ready <= 1'b0;
        sink_hold_left--;
      end else begin
        out_if.ready <= !(sink_idle_en && $urandom_range(99) < 30);
      end
    end
  end

  // One input transaction, with an optional random gap in front
  task automatic send_glyph_byte(input logic [7:0] bits, input logic [8:0] x,
                                 input logic [7:0] y, input logic [15:0] colour);
    while (src_idle_en && $urandom_range(99) < 30) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.glyph_byte <= bits;
    in_if.pos_x      <= x;
    in_if.pos_y      <= y;
    in_if.fg_color   <= colour;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Random glyph byte, with the field extremes favoured
  task automatic send_random_byte();
    logic [7:0]  bits;
    logic [8:0]  x;
    logic [7:0]  y;
    logic [15:0] colour;
    case ($urandom_range(7))
      0:       bits = 8'h00;
      1:       bits = 8'hFF;
      default: bits = 8'($urandom);
    endcase
    x      = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 9'd511 : 9'd0)
                                      : 9'($urandom_range(511));
    y      = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0) : 8'($urandom);
    colour = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                      : 16'($urandom);
    send_glyph_byte(bits, x, y, colour);
  endtask

  // Pause until every expected SPI byte has come, plus a short settling margin
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Both offsets, then a write to an unused index that must change nothing
  task automatic set_offsets(input logic [7:0] col, input logic [7:0] row);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgColOffset;
    cfg_wdata_i <= col;
    @(posedge clk_i);
    cfg_idx_i   <= CfgRowOffset;
    cfg_wdata_i <= row;
    @(posedge clk_i);
    cfg_idx_i   <= $urandom_range(1) ? CfgIdxSpareLo : CfgIdxSpareHi;
    cfg_wdata_i <= 8'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    offset_settings++;
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_wdata_i      = '0;
    in_if.valid      = 1'b0;
    in_if.glyph_byte = '0;
    in_if.pos_x      = '0;
    in_if.pos_y      = '0;
    in_if.fg_color   = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset offsets, glyph at the origin, then later bytes whose
    // position and colour fields must be ignored
    send_glyph_byte(8'hFF, 9'd0, 8'd0, 16'hFFFF);
    send_glyph_byte(8'h00, 9'd511, 8'd255, 16'h0000);
    send_glyph_byte(8'h01, 9'd511, 8'd255, 16'hFFFF);
    send_glyph_byte(8'h80, 9'd0, 8'd0, 16'h0000);
    send_glyph_byte(8'hAA, 9'd511, 8'd0, 16'h1234);
    send_glyph_byte(8'h55, 9'd0, 8'd255, 16'hFFFF);
    wait_drained();

    // Random phases, each under its own offsets; glyphs run across phases
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       set_offsets(8'hFF, 8'hFF);
        1:       set_offsets(8'h00, 8'hFF);
        2:       set_offsets(8'hFF, 8'h00);
        5:       set_offsets(8'h00, 8'h00);
        default: set_offsets(8'($urandom), 8'($urandom));
      endcase
      // Long receiver hold-off while the sender keeps offering
      if (phase == 2) begin
        sink_hold_left = SinkHoldCycles;
      end
      // A stretch with no idling on either side
      src_idle_en  = (phase != 3);
      sink_idle_en = (phase != 3);
      for (int n = 0; n < PhaseItems; n++) begin
        send_random_byte();
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    $display("Run covered %0d glyph bytes (%0d whole glyphs) and %0d SPI bytes checked,",
             glyph_bytes, glyphs, spi_bytes);
    $display("under %0d panel offset settings including both extremes and back-pressure.",
             offset_settings);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/glcd_pkg.sv
rtl/glcd_if.sv
rtl/glcd_front.sv
rtl/glcd_queue.sv
rtl/glcd_back.sv
rtl/glyph_to_lcd_spi_stream.sv
verif/glcd_spi_scoreboard.sv
verif/tb_top.sv
